// ===== src/ivs_pkg.sv =====
package ivs_pkg;

   localparam int DEPTH  = 16;
   localparam int WIDTH  = 32;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = 4;
   localparam int DATA_W = 32;
   localparam int LEN_W  = 5;
   localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_PUSH   = 2'd2,
      ACT_POP    = 2'd3
   } ivs_action_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_BOUNDS = 2'd2,
      STAT_EMPTY  = 2'd3
   } ivs_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_GRAB,
      ST_SHIFT,
      ST_TRIM,
      ST_RESULT
   } ivs_state_type;

   typedef struct packed {
      ivs_action_type      action;
      logic [IDX_W-1:0]    index;
      logic [DATA_W-1:0]   item_data;
   } ivs_req_type;

   typedef struct packed {
      ivs_status_type      status;
      logic [DATA_W-1:0]   removed_data;
      logic [LEN_W-1:0]    length;
   } ivs_rsp_type;

   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [WIDTH-1:0]    wr_data;
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr;
      logic                clr_en;
      logic [ADDR_W-1:0]   clr_addr;
   } ivs_mem_req_type;

endpackage

// ===== src/ivs_ram.sv =====
module ivs_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ivs_store.sv =====
module ivs_store
   import ivs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ivs_mem_req_type mem_req,
   output logic [WIDTH-1:0] rd_data
);

   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic             rd_valid_ff;
   logic             rd_valid_in;
   logic [WIDTH-1:0] ram_q;

   ivs_ram #(
      .DATA_W (WIDTH),
      .DEPTH  (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (ram_q)
   );

   // unwritten or vacated slots read as zero
   always_comb begin
      valid_in = valid_ff;
      if (mem_req.clr_en) begin
         valid_in[mem_req.clr_addr] = 1'b0;
      end
      if (mem_req.wr_en) begin
         valid_in[mem_req.wr_addr] = 1'b1;
      end
      rd_valid_in = rd_valid_ff;
      if (mem_req.rd_en) begin
         rd_valid_in = valid_ff[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign rd_data = rd_valid_ff ? ram_q : '0;

endmodule

// ===== src/ivs_ctrl.sv =====
module ivs_ctrl
   import ivs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ivs_req_type     req_data,
   output ivs_mem_req_type mem_req,
   input  logic [WIDTH-1:0] rd_data,
   output logic            done_valid,
   output ivs_rsp_type     done_data,
   input  logic            out_free
);

   ivs_state_type    state_ff, state_in;
   ivs_action_type   op_ff, op_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [WIDTH-1:0] data_ff, data_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [WIDTH-1:0] taken_ff, taken_in;
   ivs_status_type   status_ff, status_in;

   logic [CMP_W-1:0] idx_cmp;
   logic [CMP_W-1:0] cnt_cmp;
   logic             ins_oob;
   logic             push_full;
   logic             is_empty;
   logic             rem_oob;
   logic             take_ok;
   logic [ADDR_W-1:0] take_pos;

   // shared pointer adder and compare for the shift loop
   logic [CNT_W-1:0] unit_off;
   logic [CNT_W-1:0] unit_sum;
   logic             unit_lt;

   assign idx_cmp   = CMP_W'(idx_ff);
   assign cnt_cmp   = CMP_W'(count_ff);
   assign ins_oob   = idx_cmp >= CMP_W'(DEPTH);
   assign push_full = count_ff == CNT_W'(DEPTH);
   assign is_empty  = count_ff == '0;
   assign rem_oob   = idx_cmp >= cnt_cmp;
   assign take_ok   = !is_empty && ((op_ff == ACT_POP) || !rem_oob);
   assign take_pos  = (op_ff == ACT_POP) ? ADDR_W'(count_ff - 1'b1) : ADDR_W'(idx_ff);

   assign unit_off = (state_ff == ST_SHIFT) ? CNT_W'(2) : CNT_W'(1);
   assign unit_sum = CNT_W'(ptr_ff) + unit_off;
   assign unit_lt  = unit_sum < count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (((op_ff == ACT_REMOVE) || (op_ff == ACT_POP)) && take_ok) begin
               state_in = ST_GRAB;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_GRAB, ST_SHIFT: begin
            state_in = unit_lt ? ST_SHIFT : ST_TRIM;
         end
         ST_TRIM: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      op_in     = op_ff;
      idx_in    = idx_ff;
      data_in   = data_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      taken_in  = taken_ff;
      status_in = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_data.action;
               idx_in  = req_data.index;
               data_in = WIDTH'(req_data.item_data);
            end
         end
         ST_EXEC: begin
            taken_in  = '0;
            status_in = STAT_OK;
            ptr_in    = take_pos;
            case (op_ff)
               ACT_INSERT: begin
                  if (ins_oob) begin
                     status_in = STAT_BOUNDS;
                  end else if (cnt_cmp <= idx_cmp) begin
                     count_in = CNT_W'(idx_ff) + 1'b1;
                  end
               end
               ACT_PUSH: begin
                  if (push_full) begin
                     status_in = STAT_FULL;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end
               ACT_REMOVE: begin
                  if (is_empty) begin
                     status_in = STAT_EMPTY;
                  end else if (rem_oob) begin
                     status_in = STAT_BOUNDS;
                  end
               end
               ACT_POP: begin
                  if (is_empty) begin
                     status_in = STAT_EMPTY;
                  end
               end
               default: begin
                  status_in = STAT_OK;
               end
            endcase
         end
         ST_GRAB: begin
            taken_in = rd_data;
         end
         ST_SHIFT: begin
            ptr_in = ptr_ff + 1'b1;
         end
         ST_TRIM: begin
            count_in = count_ff - 1'b1;
         end
         default: begin
            op_in = op_ff;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready        = 1'b0;
      done_valid       = 1'b0;
      mem_req          = '0;
      mem_req.wr_data  = data_ff;
      mem_req.wr_addr  = ADDR_W'(idx_ff);
      mem_req.rd_addr  = ADDR_W'(unit_sum);
      mem_req.clr_addr = ADDR_W'(count_ff - 1'b1);
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_EXEC: begin
            mem_req.rd_addr = take_pos;
            if ((op_ff == ACT_INSERT) && !ins_oob) begin
               mem_req.wr_en = 1'b1;
            end else if ((op_ff == ACT_PUSH) && !push_full) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = ADDR_W'(count_ff);
            end else if (((op_ff == ACT_REMOVE) || (op_ff == ACT_POP)) && take_ok) begin
               mem_req.rd_en = 1'b1;
            end
         end
         ST_GRAB: begin
            mem_req.rd_en = unit_lt;
         end
         ST_SHIFT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ptr_ff;
            mem_req.wr_data = rd_data;
            mem_req.rd_en   = unit_lt;
         end
         ST_TRIM: begin
            mem_req.clr_en = 1'b1;
         end
         ST_RESULT: begin
            done_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign done_data.status       = status_ff;
   assign done_data.removed_data = DATA_W'(taken_ff);
   assign done_data.length       = LEN_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      data_ff   <= data_in;
      ptr_ff    <= ptr_in;
      taken_ff  <= taken_in;
      status_ff <= status_in;
   end

`ifndef SYNTHESIS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> ((CNT_W'(ptr_ff) + 1'b1) < count_ff))
      else $error("shift source past end");

   a_trim_dec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRIM) |=> (count_ff == CNT_W'($past(count_ff) - 1'b1)))
      else $error("trim did not shorten count");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (done_valid && (done_data.status != STAT_OK)) |-> (done_data.removed_data == '0))
      else $error("failed operation returned data");
`endif

endmodule

// ===== src/indexed_vector_store.sv =====
// Fixed-capacity vector of DEPTH words with insert, remove, push and pop; every request
// gets one response carrying status, removed word and the new length. A request is taken
// only while the sequencer is idle. Insert, push and any failed operation pass through the
// execute and result states. Remove and pop also pass through grab, then a shift state
// for each entry after the removed position, then trim: the later entries move down one per
// cycle through the single read port of the entry RAM.
// A finished response waits in an output register, so a new request can be taken while
// the previous response is still pending.
module indexed_vector_store
   import ivs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ivs_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ivs_rsp_type rsp_data
);

   ivs_mem_req_type  mem_req;
   logic [WIDTH-1:0] rd_data;
   logic             done_valid;
   ivs_rsp_type      done_data;
   logic             out_free;
   logic             rsp_valid_ff, rsp_valid_in;
   ivs_rsp_type      rsp_data_ff, rsp_data_in;

   ivs_store u_store (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   ivs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .done_valid (done_valid),
      .done_data  (done_data),
      .out_free   (out_free)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/sv/indexed_vector_store_tb.sv =====
module indexed_vector_store_tb
   import ivs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ivs_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ivs_rsp_type rsp_data;

   logic [WIDTH-1:0] vec_words [DEPTH];
   int unsigned      vec_len;
   ivs_rsp_type      rsp_expected [$];
   int               fail_count = 0;
   int               snd_idle_pct = 0;
   int               rcv_idle_pct = 0;

   indexed_vector_store uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= rcv_idle_pct);
   end

   // take out one entry, shift later ones down, clear the vacated top slot
   function automatic logic [WIDTH-1:0] take_entry(int unsigned pos);
      logic [WIDTH-1:0] word;
      word = vec_words[pos];
      for (int unsigned i = pos; i + 1 < vec_len; i++) begin
         vec_words[i] = vec_words[i + 1];
      end
      vec_len--;
      vec_words[vec_len] = '0;
      return word;
   endfunction

   function automatic ivs_rsp_type apply_vector_op(ivs_req_type op);
      ivs_rsp_type r;
      r.status = STAT_OK;
      r.removed_data = '0;
      case (op.action)
         ACT_INSERT: begin
            if (int'(op.index) >= DEPTH) begin
               r.status = STAT_BOUNDS;
            end else begin
               vec_words[op.index] = op.item_data[WIDTH-1:0];
               if (vec_len <= op.index) vec_len = op.index + 1;
            end
         end
         ACT_REMOVE: begin
            if (vec_len == 0) r.status = STAT_EMPTY;
            else if (op.index >= vec_len) r.status = STAT_BOUNDS;
            else r.removed_data = DATA_W'(take_entry(op.index));
         end
         ACT_PUSH: begin
            if (vec_len >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               vec_words[vec_len] = op.item_data[WIDTH-1:0];
               vec_len++;
            end
         end
         default: begin
            if (vec_len == 0) r.status = STAT_EMPTY;
            else r.removed_data = DATA_W'(take_entry(vec_len - 1));
         end
      endcase
      r.length = LEN_W'(vec_len);
      return r;
   endfunction

   task automatic report_failure(string what, ivs_rsp_type want, ivs_rsp_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s: expected status %0d data %h length %0d, got status %0d data %h length %0d",
                  what, want.status, want.removed_data, want.length,
                  got.status, got.removed_data, got.length);
      end
   endtask

   always @(posedge clock) begin : check_rsp
      ivs_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_expected.size() == 0) begin
            report_failure("unexpected transfer", '0, rsp_data);
         end else begin
            want = rsp_expected.pop_front();
            if (want.status !== rsp_data.status || want.removed_data !== rsp_data.removed_data
                || want.length !== rsp_data.length) begin
               report_failure("response mismatch", want, rsp_data);
            end
         end
      end
   end

   task automatic send_op(ivs_action_type act, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] word);
      ivs_req_type op;
      op.action = act;
      op.index = idx;
      op.item_data = word;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= op;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rsp_expected.push_back(apply_vector_op(op));
   endtask

   task automatic test_empty_vector();
      send_op(ACT_REMOVE, 4'd0, 32'h0);
      send_op(ACT_REMOVE, 4'd15, 32'hFFFF_FFFF);
      send_op(ACT_POP, 4'd7, 32'h1234_5678);
   endtask

   // inserts past the end leave zero words behind
   task automatic test_sparse_insert();
      send_op(ACT_INSERT, 4'd5, 32'hFFFF_FFFF);
      send_op(ACT_INSERT, 4'd2, 32'h0000_0001);
      send_op(ACT_REMOVE, 4'd2, 32'h0);
      send_op(ACT_REMOVE, 4'd5, 32'h0);
      send_op(ACT_POP, 4'd0, 32'h0);
      send_op(ACT_POP, 4'd15, 32'h0);
      send_op(ACT_REMOVE, 4'd0, 32'h0);
      send_op(ACT_POP, 4'd0, 32'h0);
      send_op(ACT_POP, 4'd0, 32'h0);
   endtask

   task automatic test_full_vector();
      send_op(ACT_INSERT, 4'd15, 32'hA5A5_A5A5);
      send_op(ACT_PUSH, 4'd0, 32'h5A5A_5A5A);
      send_op(ACT_INSERT, 4'd0, 32'hFFFF_FFFF);
      send_op(ACT_REMOVE, 4'd0, 32'h0);
      send_op(ACT_PUSH, 4'd3, 32'h1234_5678);
      send_op(ACT_REMOVE, 4'd15, 32'h0);
      send_op(ACT_REMOVE, 4'd15, 32'h0);
      send_op(ACT_INSERT, 4'd15, 32'h0000_0000);
   endtask

   // drifts between empty and full; a tenth of the traffic is unconstrained noise
   task automatic test_random_ops(int n_ops);
      bit               filling;
      int unsigned      sel;
      logic [DATA_W-1:0] word;
      logic [IDX_W-1:0] idx;
      filling = 1'b1;
      for (int n = 0; n < n_ops; n++) begin
         if (vec_len == DEPTH) filling = 1'b0;
         else if (vec_len == 0) filling = 1'b1;
         else if ($urandom_range(19) == 0) filling = !filling;
         case ($urandom_range(9))
            0: word = '0;
            1: word = '1;
            default: word = $urandom;
         endcase
         sel = $urandom_range(99);
         if (sel < 10) begin
            send_op(ivs_action_type'($urandom_range(3)), IDX_W'($urandom_range(15)), word);
         end else if ((filling && sel < 75) || (!filling && sel >= 75)) begin
            if ($urandom_range(1)) begin
               send_op(ACT_PUSH, IDX_W'($urandom_range(15)), word);
            end else begin
               if ($urandom_range(4) == 0) idx = IDX_W'($urandom_range(15));
               else idx = IDX_W'($urandom_range(vec_len < DEPTH ? vec_len : DEPTH - 1));
               send_op(ACT_INSERT, idx, word);
            end
         end else begin
            if ($urandom_range(1) || vec_len == 0) begin
               send_op(ACT_POP, IDX_W'($urandom_range(15)), word);
            end else begin
               send_op(ACT_REMOVE, IDX_W'($urandom_range(vec_len - 1)), word);
            end
         end
      end
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) vec_words[i] = '0;
      vec_len = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      snd_idle_pct = 7;
      rcv_idle_pct = 48;
      test_empty_vector();
      test_sparse_insert();
      test_full_vector();
      test_random_ops(180);

      snd_idle_pct = 48;
      rcv_idle_pct = 7;
      test_random_ops(180);

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      test_random_ops(190);
      req_valid <= 1'b0;

      wait (rsp_expected.size() == 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
